// ===== src/cubic_bezier_path_eval_top_defines.svh =====
// Assertion macros shared by the checker of the cubic Bezier path evaluator.
// No dependencies; included by files that hold concurrent assertions.
`ifndef CUBIC_BEZIER_PATH_EVAL_TOP_DEFINES_SVH
`define CUBIC_BEZIER_PATH_EVAL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CBPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CBPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cbpe_pkg.sv =====
// Shared constants, types and codes of the cubic Bezier path evaluator.
// No dependencies; imported by every module of the block.
package cbpe_pkg;

    localparam int COORD_W     = 16;
    localparam int T_FRAC      = 16;
    localparam int T_W         = 17;
    localparam int GUARD       = 8;
    localparam int COEF_W      = COORD_W + 5;
    localparam int ACC_W       = 31;
    localparam int PROD_W      = ACC_W + T_W + 1;
    localparam int OUT_W       = 18;
    localparam int OUT_MAX     = 131071;
    localparam int OUT_MIN     = -131072;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_AXES    = 3;
    localparam int LANE_LAT    = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [OUT_W-1:0]  t_pos;

    typedef struct packed {
        t_coef a;
        t_coef b;
        t_coef c;
        t_coef d;
    } t_axis_coef;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_POS = 2'd0,
        CFG_START_VEL = 2'd1,
        CFG_END_POS   = 2'd2,
        CFG_END_VEL   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_LATCH = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

endpackage

// ===== src/cbpe_lane.sv =====
// One axis of the Horner evaluation pipeline: three multiply and round-add steps,
// then the final rounding and saturation. Depends on cbpe_pkg.
module cbpe_lane import cbpe_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [T_W-1:0] i_t,
    input  t_axis_coef     i_coef,
    output t_pos           o_pos
);

    function automatic logic signed [ACC_W-1:0] coef_acc(input t_coef c);
        logic signed [ACC_W-1:0] v;
        v = ACC_W'(c);
        return v <<< GUARD;
    endfunction

    function automatic logic signed [PROD_W-1:0] mul_t(input logic signed [ACC_W-1:0] acc,
                                                       input logic [T_W-1:0] t);
        return PROD_W'(acc) * PROD_W'($signed({1'b0, t}));
    endfunction

    function automatic logic signed [ACC_W-1:0] round_t(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + (PROD_W'(1) <<< (T_FRAC - 1));
        s = s >>> T_FRAC;
        return ACC_W'(s);
    endfunction

    function automatic t_pos round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        s  = acc + (ACC_W'(1) <<< (GUARD - 1));
        s  = s >>> GUARD;
        hi = ACC_W'(OUT_MAX);
        lo = ACC_W'(OUT_MIN);
        if (s > hi) begin
            return OUT_W'(hi);
        end else if (s < lo) begin
            return OUT_W'(lo);
        end
        return OUT_W'(s);
    endfunction

    logic signed [PROD_W-1:0] r_prod1, r_prod3, r_prod5;
    logic signed [ACC_W-1:0]  r_acc2, r_acc4, r_acc6;
    logic [T_W-1:0]           r_t1, r_t2, r_t3, r_t4;
    t_coef                    r_b1, r_c1, r_c2, r_c3, r_d1, r_d2, r_d3, r_d4, r_d5;
    t_pos                     r_pos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1 <= mul_t(coef_acc(i_coef.a), i_t);
            r_t1    <= i_t;
            r_b1    <= i_coef.b;
            r_c1    <= i_coef.c;
            r_d1    <= i_coef.d;

            r_acc2  <= round_t(r_prod1) + coef_acc(r_b1);
            r_t2    <= r_t1;
            r_c2    <= r_c1;
            r_d2    <= r_d1;

            r_prod3 <= mul_t(r_acc2, r_t2);
            r_t3    <= r_t2;
            r_c3    <= r_c2;
            r_d3    <= r_d2;

            r_acc4  <= round_t(r_prod3) + coef_acc(r_c3);
            r_t4    <= r_t3;
            r_d4    <= r_d3;

            r_prod5 <= mul_t(r_acc4, r_t4);
            r_d5    <= r_d4;

            r_acc6  <= round_t(r_prod5) + coef_acc(r_d5);

            r_pos   <= round_sat(r_acc6);
        end
    end

    assign o_pos = r_pos;

endmodule

// ===== src/cubic_bezier_path_eval_top.sv =====
// Channel   | Signals                         | Content (lowest bit first)
// s_axis    | tvalid tready tdata[23:0] tuser | tdata: t (17), zero pad; tuser: op
// m_axis    | tvalid tready tdata[55:0] tuser | tdata: pos_x, pos_y, pos_z, pad; tuser: ready_res
// cfg       | i_cfg_we i_cfg_idx i_cfg_wdata  | write of one 48-bit register, no read-back
//
// One request enters per cycle while the output is not stalled; each result leaves after an input
// register and seven lane stages (three multiplies, three round-adds, one saturation).
// The whole pipeline advances when the output register is empty or being taken, so a
// stall holds every stage in place. Reset is synchronous and clears the valid bits, the
// registers, the coefficients and the ready flag. Depends on cbpe_pkg and cbpe_lane.
module cubic_bezier_path_eval_top import cbpe_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // t[16:0], pad
    input  logic                   s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pos_x, pos_y, pos_z, pad
    output logic                   m_axis_tuser,   // ready_res
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    function automatic t_axis_coef calc_coef(input logic [COORD_W-1:0] sp,
                                             input logic [COORD_W-1:0] sv,
                                             input logic [COORD_W-1:0] ep,
                                             input logic [COORD_W-1:0] ev);
        t_coef      p0, p1, p2, p3;
        t_axis_coef c;
        p0  = COEF_W'($signed(sp));
        p1  = p0 + COEF_W'($signed(sv));
        p3  = COEF_W'($signed(ep));
        p2  = p3 - COEF_W'($signed(ev));
        c.a = p3 - ((p2 <<< 1) + p2) + ((p1 <<< 1) + p1) - p0;
        c.b = ((p2 <<< 1) + p2) - ((p1 <<< 2) + (p1 <<< 1)) + ((p0 <<< 1) + p0);
        c.c = ((p1 <<< 1) + p1) - ((p0 <<< 1) + p0);
        c.d = p0;
        return c;
    endfunction

    logic [CFG_W-1:0] r_start_pos, r_start_vel, r_end_pos, r_end_vel;
    t_axis_coef       r_coef [NUM_AXES];
    t_axis_coef       n_coef [NUM_AXES];
    logic             r_ready;

    logic             w_en;
    logic             w_accept;
    t_op              w_op;
    logic [T_W-1:0]   w_t_in;
    logic [T_W-1:0]   n_t0;

    logic [LANE_LAT:0] r_vld;
    logic [LANE_LAT:0] r_live;
    logic [LANE_LAT:0] r_rdy;
    logic [T_W-1:0]    r_t0;
    t_axis_coef        r_coef0 [NUM_AXES];
    t_pos              w_pos [NUM_AXES];

    assign w_en          = !r_vld[LANE_LAT] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_t_in        = s_axis_tdata[T_W-1:0];
    assign n_t0          = (w_t_in > T_ONE) ? T_ONE : w_t_in;

    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            n_coef[ax] = calc_coef(r_start_pos[ax*COORD_W +: COORD_W],
                                   r_start_vel[ax*COORD_W +: COORD_W],
                                   r_end_pos[ax*COORD_W +: COORD_W],
                                   r_end_vel[ax*COORD_W +: COORD_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos <= '0;
            r_start_vel <= '0;
            r_end_pos   <= '0;
            r_end_vel   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_POS: r_start_pos <= i_cfg_wdata;
                CFG_START_VEL: r_start_vel <= i_cfg_wdata;
                CFG_END_POS:   r_end_pos   <= i_cfg_wdata;
                CFG_END_VEL:   r_end_vel   <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_coef[ax] <= '0;
            end
        end else if (i_cfg_we) begin
            r_ready <= 1'b0;
        end else if (w_accept && w_op == OP_LATCH) begin
            r_ready <= 1'b1;
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_coef[ax] <= n_coef[ax];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_live <= '0;
            r_rdy  <= '0;
        end else if (w_en) begin
            r_vld  <= {r_vld[LANE_LAT-1:0], s_axis_tvalid};
            r_live <= {r_live[LANE_LAT-1:0], w_op == OP_EVAL && r_ready};
            r_rdy  <= {r_rdy[LANE_LAT-1:0], w_op == OP_LATCH || r_ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0 <= n_t0;
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_coef0[ax] <= r_coef[ax];
            end
        end
    end

    for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_lane
        cbpe_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_t    (r_t0),
            .i_coef (r_coef0[ax]),
            .o_pos  (w_pos[ax])
        );
    end

    always_comb begin
        m_axis_tdata = '0;
        if (r_live[LANE_LAT]) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                m_axis_tdata[ax*OUT_W +: OUT_W] = w_pos[ax];
            end
        end
    end

    assign m_axis_tvalid = r_vld[LANE_LAT];
    assign m_axis_tuser  = r_rdy[LANE_LAT];

endmodule

// ===== src/cbpe_checker.sv =====
// Port-level assertions for the cubic Bezier path evaluator, bound to its top level.
// Depends on cbpe_pkg and the assertion macros in the defines header.
`include "cubic_bezier_path_eval_top_defines.svh"

module cbpe_checker import cbpe_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // A stalled result keeps its value until it is taken.
    `CBPE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // A result without latched coefficients carries zero coordinates.
    `CBPE_ASSERT_IMP(a_not_ready_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "result without ready flag is not zero")

    // An empty output register never blocks a new request.
    `CBPE_ASSERT_IMP(a_empty_takes, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input blocked while output is empty")

    // The pipeline is empty in the first cycle after reset.
    `CBPE_ASSERT_IMP(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !m_axis_tvalid, "result present right after reset")

endmodule

bind cubic_bezier_path_eval_top cbpe_checker u_cbpe_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for cubic_bezier_path_eval_top: a scoreboard class predicts
// every result from the register writes and requests it sees, while plain tasks drive
// the stream and register ports. Depends on cbpe_pkg and the block's RTL.
module tb_top;
    import cbpe_pkg::*;

    localparam int RANDOM_REQUESTS = 1900;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        t_pos x;
        t_pos y;
        t_pos z;
        logic rdy;
    } t_point;

    class bezier_point_tracker;
        logic [CFG_W-1:0] regs [4] = '{default: '0};
        longint coef [3][4];
        bit ready;
        t_point pending_points [$];
        int mismatches;
        int checked;
        int requests;
        int latches;
        int clamped;
        int writes;

        function void write_register(t_cfg_idx idx, logic [CFG_W-1:0] value);
            regs[idx] = value;
            ready = 1'b0;
            writes++;
        endfunction

        function longint coord(logic [CFG_W-1:0] r, int axis);
            return longint'($signed(r[axis*COORD_W +: COORD_W]));
        endfunction

        function void latch_coefficients();
            longint p0, p1, p2, p3;
            for (int a = 0; a < NUM_AXES; a++) begin
                p0 = coord(regs[CFG_START_POS], a);
                p1 = p0 + coord(regs[CFG_START_VEL], a);
                p3 = coord(regs[CFG_END_POS], a);
                p2 = p3 - coord(regs[CFG_END_VEL], a);
                coef[a][0] = p3 - 3 * p2 + 3 * p1 - p0;
                coef[a][1] = 3 * p2 - 6 * p1 + 3 * p0;
                coef[a][2] = 3 * p1 - 3 * p0;
                coef[a][3] = p0;
            end
            ready = 1'b1;
        endfunction

        function t_pos horner(int axis, longint t);
            longint acc;
            acc = coef[axis][0] <<< GUARD;
            for (int k = 1; k < 4; k++) begin
                acc = ((acc * t + (longint'(1) <<< (T_FRAC - 1))) >>> T_FRAC)
                    + (coef[axis][k] <<< GUARD);
            end
            acc = (acc + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
            if (acc > OUT_MAX) begin
                acc = OUT_MAX;
            end
            if (acc < OUT_MIN) begin
                acc = OUT_MIN;
            end
            return t_pos'(acc);
        endfunction

        function void note_request(t_op op, logic [T_W-1:0] t);
            t_point p;
            longint tc;
            p = '0;
            requests++;
            if (op == OP_LATCH) begin
                latch_coefficients();
                latches++;
            end else if (ready) begin
                tc = longint'(t);
                if (t > T_ONE) begin
                    tc = longint'(T_ONE);
                    clamped++;
                end
                p.x = horner(0, tc);
                p.y = horner(1, tc);
                p.z = horner(2, tc);
            end
            p.rdy = ready;
            pending_points.push_back(p);
        endfunction

        function void check_point(logic [OUT_TDATA_W-1:0] data, logic rdy);
            t_point got;
            t_point exp_p;
            got.x = t_pos'(data[OUT_W-1:0]);
            got.y = t_pos'(data[2*OUT_W-1:OUT_W]);
            got.z = t_pos'(data[3*OUT_W-1:2*OUT_W]);
            got.rdy = rdy;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("tb_top: result with nothing pending: x=%0d y=%0d z=%0d ready=%0b",
                             got.x, got.y, got.z, got.rdy);
                end
                return;
            end
            exp_p = pending_points.pop_front();
            checked++;
            if (got.x !== exp_p.x || got.y !== exp_p.y || got.z !== exp_p.z
                    || got.rdy !== exp_p.rdy) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("tb_top: mismatch at result %0d: expected x=%0d y=%0d z=%0d ready=%0b",
                             checked, exp_p.x, exp_p.y, exp_p.z, exp_p.rdy);
                    $display("tb_top:     got x=%0d y=%0d z=%0d ready=%0b",
                             got.x, got.y, got.z, got.rdy);
                end
            end
        endfunction

        function bit clean();
            if (pending_points.size() != 0) begin
                $display("tb_top: %0d results never arrived", pending_points.size());
            end
            return mismatches == 0 && pending_points.size() == 0;
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // t[16:0], pad
    logic                   s_axis_tuser = 1'b0; // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // pos_x, pos_y, pos_z, pad
    logic                   m_axis_tuser;        // ready_res
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    bezier_point_tracker board;
    int  sender_idle_pct = 37;
    int  receiver_idle_pct = 84;
    logic rx_hold = 1'b0;
    bit  pressure_req = 1'b0;
    int  idle_cycles = 0;

    cubic_bezier_path_eval_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial begin
        wait (pressure_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                board.write_register(t_cfg_idx'(i_cfg_idx), i_cfg_wdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_request(t_op'(s_axis_tuser), s_axis_tdata[T_W-1:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_point(m_axis_tdata, m_axis_tuser);
            end
            if (i_cfg_we || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("tb_top: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [CFG_W-1:0] random_vector(bit extreme);
        logic [CFG_W-1:0] v;
        logic [COORD_W-1:0] corners [4];
        corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        for (int a = 0; a < NUM_AXES; a++) begin
            v[a*COORD_W +: COORD_W] = extreme ? corners[$urandom_range(3)]
                                              : COORD_W'($urandom);
        end
        return v;
    endfunction

    function automatic logic [T_W-1:0] random_t();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return T_ONE;
        end else if (r < 12) begin
            return '0;
        end else if (r < 20) begin
            return T_W'($urandom_range(131071, 65537));
        end
        return T_W'($urandom_range(65536, 0));
    endfunction

    task automatic send_request(t_op op, logic [T_W-1:0] t);
        bit gap;
        gap = 1'b0;
        while ($urandom_range(99) < sender_idle_pct) begin
            if (!gap) begin
                s_axis_tvalid <= 1'b0;
                gap = 1'b1;
            end
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(t);
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_registers(logic [3:0] mask, logic [CFG_W-1:0] vals [4]);
        bit wrote;
        wrote = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                i_cfg_we    <= 1'b1;
                i_cfg_idx   <= t_cfg_idx'(i);
                i_cfg_wdata <= vals[i];
                wrote = 1'b1;
                @(posedge i_clk);
            end
        end
        if (wrote) begin
            i_cfg_we <= 1'b0;
        end
    endtask

    task automatic run_segment(int count);
        logic [CFG_W-1:0] vals [4];
        logic [3:0] mask;
        bit extreme;
        extreme = ($urandom_range(5) == 0);
        mask = 4'($urandom_range(15));
        foreach (vals[i]) vals[i] = random_vector(extreme);
        load_registers(mask, vals);
        if ($urandom_range(9) == 0) begin
            send_request(OP_EVAL, random_t());
        end
        if ($urandom_range(9) != 0) begin
            send_request(OP_LATCH, T_W'($urandom));
        end
        for (int k = 0; k < count; k++) begin
            send_request(t_op'(($urandom_range(19) == 0) ? OP_LATCH : OP_EVAL), random_t());
        end
    endtask

    initial begin
        logic [CFG_W-1:0] vals [4];
        int directed;
        int phase;
        board = new;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing latched yet, then a latch of the all-zero reset curve.
        send_request(OP_EVAL, '0);
        send_request(OP_EVAL, 17'h1FFFF);
        send_request(OP_LATCH, 17'h1FFFF);
        send_request(OP_EVAL, T_ONE);
        wait_idle();

        // Coordinates at both ends of their range, t over its whole span.
        vals = '{48'h8000_0000_7FFF, 48'h8000_7FFF_7FFF,
                 48'h7FFF_8000_8000, 48'h7FFF_7FFF_8000};
        load_registers(4'hF, vals);
        send_request(OP_EVAL, 17'h08000);
        send_request(OP_LATCH, '0);
        send_request(OP_EVAL, '0);
        send_request(OP_EVAL, 17'h00001);
        send_request(OP_EVAL, 17'h08000);
        send_request(OP_EVAL, 17'h0FFFF);
        send_request(OP_EVAL, T_ONE);
        send_request(OP_EVAL, T_ONE + 17'd1);
        send_request(OP_EVAL, 17'h1FFFF);
        send_request(OP_EVAL, 17'h15555);
        wait_idle();

        // A single register write must drop the ready flag until the next latch.
        vals[CFG_END_VEL] = random_vector(1'b0);
        load_registers(4'b1000, vals);
        send_request(OP_EVAL, 17'h04000);
        send_request(OP_LATCH, '0);
        send_request(OP_EVAL, 17'h04000);
        send_request(OP_EVAL, 17'h0F0F0);
        wait_idle();
        directed = board.requests;

        while (board.requests < directed + RANDOM_REQUESTS) begin
            phase = (board.requests - directed) * 3 / RANDOM_REQUESTS;
            if (phase == 0) begin
                sender_idle_pct = 37;
                receiver_idle_pct = 84;
            end else if (phase == 1) begin
                sender_idle_pct = 84;
                receiver_idle_pct = 37;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
                pressure_req = 1'b1;
            end
            run_segment($urandom_range(80, 20));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d requests (%0d latches, %0d with t clamped), %0d results checked",
                 board.requests, board.latches, board.clamped, board.checked);
        $display("tb_top: %0d register writes, %0d mismatches, long output stall included",
                 board.writes, board.mismatches);
        if (board.clean()) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/cbpe_pkg.sv
src/cbpe_lane.sv
src/cubic_bezier_path_eval_top.sv
src/cbpe_checker.sv
sim/tb_top.sv
